/* rtl/core/smi_pkg.sv */
package smi_pkg;

	// Element format: signed fixed point, FRAC fraction bits
	localparam int ELEM_W = 32;
	localparam int FRAC   = 16;
	localparam int NLANE  = 9;

	// Internal widths
	localparam int PROD_W = 2 * ELEM_W;            // one element product
	localparam int ADJ_W  = 2 * ELEM_W + 1;        // one cofactor
	localparam int DET_W  = 3 * ELEM_W + 3;        // exact determinant
	localparam int LO_W   = ELEM_W + 1;            // low split of a cofactor
	localparam int HI_W   = ADJ_W - LO_W;          // high split of a cofactor
	localparam int DEN_W  = DET_W + 1;             // twice the determinant magnitude
	localparam int REM_W  = DET_W + ELEM_W + 2;    // divider remainder
	localparam int DV_W   = 64;                    // determinant output
	localparam int LIM_W  = 32;                    // singular limit
	localparam int IDX_W  = 4;                     // element index

	// Pipeline stage numbers
	localparam int MERGE_OUT_STAGE = 9;
	localparam int DIV_OUT_STAGE   = ELEM_W + 10;
	localparam int OUT_STAGE       = DIV_OUT_STAGE + 1;

	// Matrix order codes
	localparam logic [1:0] MODE_1 = 2'd1;
	localparam logic [1:0] MODE_2 = 2'd2;
	localparam logic [1:0] MODE_3 = 2'd3;

	typedef struct packed {
		logic [1:0]               mode;
		logic signed [ELEM_W-1:0] elem0;
		logic signed [ELEM_W-1:0] elem1;
		logic signed [ELEM_W-1:0] elem2;
		logic signed [ELEM_W-1:0] elem3;
		logic signed [ELEM_W-1:0] elem4;
		logic signed [ELEM_W-1:0] elem5;
		logic signed [ELEM_W-1:0] elem6;
		logic signed [ELEM_W-1:0] elem7;
		logic signed [ELEM_W-1:0] elem8;
	} src_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] inv0;
		logic signed [ELEM_W-1:0] inv1;
		logic signed [ELEM_W-1:0] inv2;
		logic signed [ELEM_W-1:0] inv3;
		logic signed [ELEM_W-1:0] inv4;
		logic signed [ELEM_W-1:0] inv5;
		logic signed [ELEM_W-1:0] inv6;
		logic signed [ELEM_W-1:0] inv7;
		logic signed [ELEM_W-1:0] inv8;
		logic signed [DV_W-1:0]   det_value;
		logic                     singular;
	} res_t;

	// Divisor handed from the merge stage to every lane
	typedef struct packed {
		logic [DET_W-1:0] mag;
		logic             neg;
	} den_t;

	// Determinant result of the merge stage
	typedef struct packed {
		logic signed [DV_W-1:0] det_value;
		logic                   singular;
		logic [1:0]             mode;
	} det_res_t;

	// Order-3 cofactor operands {a, b, c, d}: cof = a*b - c*d
	function automatic logic [4*IDX_W-1:0] cof3_ops(input logic [IDX_W-1:0] lane);
		logic [4*IDX_W-1:0] r;
		case (lane)
			4'd0:    r = {4'd4, 4'd8, 4'd5, 4'd7};
			4'd1:    r = {4'd2, 4'd7, 4'd1, 4'd8};
			4'd2:    r = {4'd1, 4'd5, 4'd2, 4'd4};
			4'd3:    r = {4'd5, 4'd6, 4'd3, 4'd8};
			4'd4:    r = {4'd0, 4'd8, 4'd2, 4'd6};
			4'd5:    r = {4'd2, 4'd3, 4'd0, 4'd5};
			4'd6:    r = {4'd3, 4'd7, 4'd4, 4'd6};
			4'd7:    r = {4'd1, 4'd6, 4'd0, 4'd7};
			4'd8:    r = {4'd0, 4'd4, 4'd1, 4'd3};
			default: r = '0;
		endcase
		return r;
	endfunction

	// Is inverse element lane part of an order-mode matrix
	function automatic logic lane_used(input logic [1:0] mode, input logic [IDX_W-1:0] lane);
		logic r;
		case (mode)
			MODE_3:  r = 1'b1;
			MODE_2:  r = (lane < 4'd4);
			MODE_1:  r = (lane == 4'd0);
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/small_matrix_inverse.sv */
// Determinant and inverse of a square matrix of order 1, 2 or 3 in signed
// Q16.16, one matrix per beat. A new matrix is taken every cycle unless the
// pipeline is held. For order 3, nine lanes each form one 2x2 cofactor, a
// merge stage sums the first row into the exact determinant, and each lane
// then divides its cofactor by it in a restoring divider of one quotient bit
// per stage; there are 32 divider stages. The determinant is returned as
// saturated Q32.32, the inverse rounded to nearest (ties away from zero) and
// saturated to Q16.16. A determinant that is zero, or whose Q32.32 magnitude
// is below singular_limit (written on the cfg port, reset value 1), raises
// singular and zeroes the inverse. Elements outside the order are zero. A
// stall on the result side while a result is waiting holds the whole
// pipeline.
module small_matrix_inverse (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        src_valid,
	output logic                        src_stall,
	input  smi_pkg::src_t               src_data,
	output logic                        res_valid,
	input  logic                        res_stall,
	output smi_pkg::res_t               res_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [smi_pkg::LIM_W-1:0]   cfg_data
);
	import smi_pkg::*;

	localparam int DL = DIV_OUT_STAGE - MERGE_OUT_STAGE;

	logic                     en;
	logic [OUT_STAGE:1]       vld_q;
	logic [LIM_W-1:0]         limit_q;
	src_t                     src_s1;
	logic signed [ELEM_W-1:0] m_s1 [NLANE];
	logic signed [ELEM_W-1:0] m_s2 [3];
	logic signed [ELEM_W-1:0] m_s3 [3];
	logic [1:0]               mode_s2, mode_s3;
	logic signed [ADJ_W-1:0]  adj_s3 [NLANE];
	logic signed [ADJ_W-1:0]  row_adj [3];
	den_t                     den_s7;
	det_res_t                 det_s [DL+1];
	logic signed [ELEM_W-1:0] quo [NLANE];
	logic signed [ELEM_W-1:0] inv [NLANE];
	res_t                     res_d, res_q;

	// Advance unless a finished beat is held; take nothing while in reset
	assign en        = !(vld_q[OUT_STAGE] && res_stall);
	assign src_stall = !en || !arst_n;
	assign cfg_ready = arst_n;
	assign res_valid = vld_q[OUT_STAGE];
	assign res_data  = res_q;

	// Singular limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[OUT_STAGE-1:1], src_valid};
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (en) begin
			src_s1 <= src_data;
		end
	end

	assign m_s1[0] = src_s1.elem0;
	assign m_s1[1] = src_s1.elem1;
	assign m_s1[2] = src_s1.elem2;
	assign m_s1[3] = src_s1.elem3;
	assign m_s1[4] = src_s1.elem4;
	assign m_s1[5] = src_s1.elem5;
	assign m_s1[6] = src_s1.elem6;
	assign m_s1[7] = src_s1.elem7;
	assign m_s1[8] = src_s1.elem8;

	// Carry the first row and the order to the merge stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s2[i] <= m_s1[i];
				m_s3[i] <= m_s2[i];
			end
			mode_s2 <= src_s1.mode;
			mode_s3 <= mode_s2;
		end
	end

	// Cofactor lanes
	for (genvar k = 0; k < NLANE; k++) begin : g_cof
		localparam logic [4*IDX_W-1:0] OPS3 = cof3_ops(IDX_W'(k));
		localparam logic [4*IDX_W-1:0] OPS2 = {4'd0, 4'd3, 4'd1, 4'd2};
		logic signed [ELEM_W-1:0] a, b, c, d;
		logic                     dsel;
		logic signed [ADJ_W-1:0]  dval;

		// Pick operands for the order in use
		always_comb begin
			a    = '0;
			b    = '0;
			c    = '0;
			d    = '0;
			dsel = 1'b1;
			dval = '0;
			case (src_s1.mode)
				MODE_3: begin
					a    = m_s1[OPS3[4*IDX_W-1:3*IDX_W]];
					b    = m_s1[OPS3[3*IDX_W-1:2*IDX_W]];
					c    = m_s1[OPS3[2*IDX_W-1:IDX_W]];
					d    = m_s1[OPS3[IDX_W-1:0]];
					dsel = 1'b0;
				end
				MODE_2: begin
					// Last lane forms the order-2 determinant
					if (k == NLANE - 1) begin
						a    = m_s1[OPS2[4*IDX_W-1:3*IDX_W]];
						b    = m_s1[OPS2[3*IDX_W-1:2*IDX_W]];
						c    = m_s1[OPS2[2*IDX_W-1:IDX_W]];
						d    = m_s1[OPS2[IDX_W-1:0]];
						dsel = 1'b0;
					end else begin
						case (k)
							0:       dval = ADJ_W'(m_s1[3]);
							1:       dval = -ADJ_W'(m_s1[1]);
							2:       dval = -ADJ_W'(m_s1[2]);
							3:       dval = ADJ_W'(m_s1[0]);
							default: dval = '0;
						endcase
					end
				end
				MODE_1: begin
					if (k == 0) begin
						dval = ADJ_W'(1);
					end
				end
				default: ;
			endcase
		end

		smi_cof_lane u_cof (
			.clk        (clk),
			.en         (en),
			.a          (a),
			.b          (b),
			.c          (c),
			.d          (d),
			.direct_sel (dsel),
			.direct_val (dval),
			.cof        (adj_s3[k])
		);
	end

	assign row_adj[0] = adj_s3[0];
	assign row_adj[1] = adj_s3[3];
	assign row_adj[2] = adj_s3[6];

	smi_det_merge u_merge (
		.clk     (clk),
		.en      (en),
		.mode    (mode_s3),
		.m       (m_s3),
		.adj     (row_adj),
		.det2    (adj_s3[NLANE-1]),
		.limit   (limit_q),
		.den     (den_s7),
		.det_res (det_s[0])
	);

	// Divider lanes
	for (genvar k = 0; k < NLANE; k++) begin : g_div
		smi_div_lane u_div (
			.clk (clk),
			.en  (en),
			.adj (adj_s3[k]),
			.den (den_s7),
			.quo (quo[k])
		);
	end

	// Hold the determinant beside the dividers
	for (genvar i = 0; i < DL; i++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				det_s[i+1] <= det_s[i];
			end
		end
	end

	// Drop the inverse when singular or outside the order
	for (genvar k = 0; k < NLANE; k++) begin : g_mask
		assign inv[k] = (!det_s[DL].singular && lane_used(det_s[DL].mode, IDX_W'(k))) ?
			quo[k] : '0;
	end

	always_comb begin
		res_d.inv0      = inv[0];
		res_d.inv1      = inv[1];
		res_d.inv2      = inv[2];
		res_d.inv3      = inv[3];
		res_d.inv4      = inv[4];
		res_d.inv5      = inv[5];
		res_d.inv6      = inv[6];
		res_d.inv7      = inv[7];
		res_d.inv8      = inv[8];
		res_d.det_value = det_s[DL].det_value;
		res_d.singular  = det_s[DL].singular;
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

endmodule

/* rtl/core/smi_cof_lane.sv */
module smi_cof_lane (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [smi_pkg::ELEM_W-1:0] a,
	input  logic signed [smi_pkg::ELEM_W-1:0] b,
	input  logic signed [smi_pkg::ELEM_W-1:0] c,
	input  logic signed [smi_pkg::ELEM_W-1:0] d,
	input  logic                             direct_sel,
	input  logic signed [smi_pkg::ADJ_W-1:0]  direct_val,
	output logic signed [smi_pkg::ADJ_W-1:0]  cof
);
	import smi_pkg::*;

	logic signed [PROD_W-1:0] p1_s2, p2_s2;
	logic                     dsel_s2;
	logic signed [ADJ_W-1:0]  dval_s2;
	logic signed [ADJ_W-1:0]  cof_s3;

	// Form both products of the 2x2 minor
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2   <= a * b;
			p2_s2   <= c * d;
			dsel_s2 <= direct_sel;
			dval_s2 <= direct_val;
		end
	end

	// Subtract, or pass the direct value as it is
	always_ff @(posedge clk) begin
		if (en) begin
			cof_s3 <= dsel_s2 ? dval_s2 : (ADJ_W'(p1_s2) - ADJ_W'(p2_s2));
		end
	end

	assign cof = cof_s3;

endmodule

/* rtl/core/smi_det_merge.sv */
module smi_det_merge (
	input  logic                             clk,
	input  logic                             en,
	input  logic [1:0]                       mode,
	input  logic signed [smi_pkg::ELEM_W-1:0] m [3],
	input  logic signed [smi_pkg::ADJ_W-1:0]  adj [3],
	input  logic signed [smi_pkg::ADJ_W-1:0]  det2,
	input  logic [smi_pkg::LIM_W-1:0]         limit,
	output smi_pkg::den_t                     den,
	output smi_pkg::det_res_t                 det_res
);
	import smi_pkg::*;

	localparam logic [DET_W-1:0] HALF = DET_W'(1) << (FRAC - 1);

	logic signed [ELEM_W+LO_W:0]  plo_s4 [3];
	logic signed [ELEM_W+HI_W-1:0] phi_s4 [3];
	logic signed [DET_W-1:0]      alt_s4, alt_s5;
	logic signed [DET_W-1:0]      prod_s5 [3];
	logic signed [DET_W-1:0]      det_s6;
	logic [1:0]                   mode_s4, mode_s5, mode_s6, mode_s7, mode_s8, mode_s9;
	den_t                         den_s7;
	logic                         zero_s7, zero_s8;
	logic [DET_W-1:0]             rd_s8;
	logic                         neg_s8;
	logic signed [DV_W-1:0]       dv_s9;
	logic                         sing_s9;
	logic                         big_pos, big_neg;

	// Split each first-row cofactor and multiply by its element
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				plo_s4[i] <= m[i] * $signed({1'b0, adj[i][LO_W-1:0]});
				phi_s4[i] <= m[i] * $signed(adj[i][ADJ_W-1:LO_W]);
			end
			case (mode)
				MODE_1:  alt_s4 <= DET_W'(m[0]);
				MODE_2:  alt_s4 <= DET_W'(det2);
				default: alt_s4 <= '0;
			endcase
			mode_s4 <= mode;
		end
	end

	// Rejoin the split products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= (DET_W'(phi_s4[i]) <<< LO_W) + DET_W'(plo_s4[i]);
			end
			alt_s5  <= alt_s4;
			mode_s5 <= mode_s4;
		end
	end

	// Sum along the first row for order 3, else take the order-1 or order-2 determinant
	always_ff @(posedge clk) begin
		if (en) begin
			det_s6  <= (mode_s5 == MODE_3) ? (prod_s5[0] + prod_s5[1] + prod_s5[2]) : alt_s5;
			mode_s6 <= mode_s5;
		end
	end

	// Take magnitude and sign
	always_ff @(posedge clk) begin
		if (en) begin
			den_s7.neg <= det_s6[DET_W-1];
			den_s7.mag <= det_s6[DET_W-1] ? DET_W'(-det_s6) : DET_W'(det_s6);
			zero_s7    <= (det_s6 == '0);
			mode_s7    <= mode_s6;
		end
	end

	// Scale to Q32.32 magnitude, rounding half away from zero for order 3
	always_ff @(posedge clk) begin
		if (en) begin
			case (mode_s7)
				MODE_3:  rd_s8 <= (den_s7.mag + HALF) >> FRAC;
				MODE_2:  rd_s8 <= den_s7.mag;
				MODE_1:  rd_s8 <= den_s7.mag << FRAC;
				default: rd_s8 <= '0;
			endcase
			neg_s8  <= den_s7.neg;
			zero_s8 <= zero_s7;
			mode_s8 <= mode_s7;
		end
	end

	// Saturate and compare against the limit
	always_comb begin
		big_pos = |rd_s8[DET_W-1:DV_W-1];
		big_neg = (|rd_s8[DET_W-1:DV_W]) || (rd_s8[DV_W-1] && (|rd_s8[DV_W-2:0]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_s8) begin
				dv_s9 <= big_pos ? {1'b0, {(DV_W-1){1'b1}}} : $signed(rd_s8[DV_W-1:0]);
			end else begin
				dv_s9 <= big_neg ? {1'b1, {(DV_W-1){1'b0}}} : -$signed(rd_s8[DV_W-1:0]);
			end
			sing_s9 <= zero_s8 || (rd_s8 < DET_W'(limit));
			mode_s9 <= mode_s8;
		end
	end

	assign den               = den_s7;
	assign det_res.det_value = dv_s9;
	assign det_res.singular  = sing_s9;
	assign det_res.mode      = mode_s9;

endmodule

/* rtl/core/smi_div_lane.sv */
module smi_div_lane (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [smi_pkg::ADJ_W-1:0]  adj,
	input  smi_pkg::den_t                     den,
	output logic signed [smi_pkg::ELEM_W-1:0] quo
);
	import smi_pkg::*;

	localparam logic [ELEM_W-1:0] POS_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] NEG_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	logic [ADJ_W-1:0]         mag_s4, mag_s5, mag_s6, mag_s7;
	logic                     neg_s4, neg_s5, neg_s6, neg_s7;
	logic [REM_W-1:0]         num_s8;
	logic [DEN_W-1:0]         dv_s8;
	logic                     qneg_s8;
	// Index j holds stage s9+j of the restoring divider
	logic [REM_W-1:0]         rem_s  [ELEM_W+1];
	logic [DEN_W-1:0]         dv_s   [ELEM_W+1];
	logic                     qneg_s [ELEM_W+1];
	logic                     ovf_s  [ELEM_W+1];
	logic [ELEM_W-1:0]        quo_s  [ELEM_W+1];
	logic signed [ELEM_W-1:0] quo_q;

	// Strip the sign of the cofactor
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s4 <= adj[ADJ_W-1];
			mag_s4 <= adj[ADJ_W-1] ? ADJ_W'(-adj) : ADJ_W'(adj);
		end
	end

	// Hold until the determinant arrives
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5 <= mag_s4;
			mag_s6 <= mag_s5;
			mag_s7 <= mag_s6;
			neg_s5 <= neg_s4;
			neg_s6 <= neg_s5;
			neg_s7 <= neg_s6;
		end
	end

	// Rounded quotient: (2|adj|*2^2F + |det|) / (2|det|)
	always_ff @(posedge clk) begin
		if (en) begin
			num_s8  <= (REM_W'(mag_s7) << (2 * FRAC + 1)) + REM_W'(den.mag);
			dv_s8   <= {den.mag, 1'b0};
			qneg_s8 <= neg_s7 ^ den.neg;
		end
	end

	// Flag quotients too large for the element width
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0]  <= num_s8 >= (REM_W'(dv_s8) << ELEM_W);
			rem_s[0]  <= num_s8;
			dv_s[0]   <= dv_s8;
			qneg_s[0] <= qneg_s8;
			quo_s[0]  <= '0;
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar j = 0; j < ELEM_W; j++) begin : g_bit
		localparam int B = ELEM_W - 1 - j;
		logic [REM_W-1:0] sub;
		logic             take;

		assign sub  = REM_W'(dv_s[j]) << B;
		assign take = (rem_s[j] >= sub);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= take ? (rem_s[j] - sub) : rem_s[j];
				quo_s[j+1]  <= quo_s[j] | (ELEM_W'(take) << B);
				dv_s[j+1]   <= dv_s[j];
				qneg_s[j+1] <= qneg_s[j];
				ovf_s[j+1]  <= ovf_s[j];
			end
		end
	end

	// Apply the sign and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			if (!qneg_s[ELEM_W]) begin
				quo_q <= (ovf_s[ELEM_W] || quo_s[ELEM_W][ELEM_W-1]) ?
					$signed(POS_MAX) : $signed(quo_s[ELEM_W]);
			end else begin
				quo_q <= (ovf_s[ELEM_W] || (quo_s[ELEM_W] > NEG_MIN)) ?
					$signed(NEG_MIN) : -$signed(quo_s[ELEM_W]);
			end
		end
	end

	assign quo = quo_q;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import smi_pkg::*;

	typedef logic signed [199:0] wide_t;

	typedef struct {
		src_t m;
		bit   typed;
		res_t r;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        src_valid;
	logic        src_stall;
	src_t        src_data;
	logic        res_valid;
	logic        res_stall;
	res_t        res_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	logic [31:0] limit_shadow;
	res_t        inverse_q[$];
	int          fail_count;
	int          burst_left;
	int          stall_mode;
	row_t        rows[$];

	small_matrix_inverse u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL small_matrix_inverse");
		$finish;
	end

	function automatic logic [63:0] clamp(wide_t a, int w);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (w - 1)) - 1;
		lo = -(wide_t'(1) <<< (w - 1));
		if (a > hi) return hi[63:0];
		if (a < lo) return lo[63:0];
		return a[63:0];
	endfunction

	// divide, rounding to nearest with ties away from zero
	function automatic wide_t round_div(wide_t num, wide_t den);
		logic [199:0] an;
		logic [199:0] ad;
		logic [199:0] q;
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		q  = (2 * an + ad) / (2 * ad);
		return ((num < 0) != (den < 0)) ? -wide_t'(q) : wide_t'(q);
	endfunction

	function automatic res_t inverse_of(src_t s, logic [31:0] lim);
		res_t        r;
		wide_t       m[9];
		wide_t       adj[9];
		wide_t       det;
		wide_t       rd;
		wide_t       mag;
		wide_t       limw;
		logic [31:0] iv[9];
		logic [63:0] sat;
		bit          sing;
		int          n;
		r = '0;
		n = s.mode;
		if (n == 0) begin
			r.singular = 1'b1;
			return r;
		end
		m[0] = s.elem0; m[1] = s.elem1; m[2] = s.elem2;
		m[3] = s.elem3; m[4] = s.elem4; m[5] = s.elem5;
		m[6] = s.elem6; m[7] = s.elem7; m[8] = s.elem8;
		for (int k = 0; k < 9; k++) begin
			adj[k] = 0;
			iv[k]  = '0;
		end
		case (n)
			1: begin
				adj[0] = 1;
				det    = m[0];
				rd     = m[0] <<< 16;
			end
			2: begin
				adj[0] = m[3];
				adj[1] = -m[1];
				adj[2] = -m[2];
				adj[3] = m[0];
				det    = m[0] * m[3] - m[1] * m[2];
				rd     = det;
			end
			default: begin
				adj[0] = m[4] * m[8] - m[5] * m[7];
				adj[1] = m[2] * m[7] - m[1] * m[8];
				adj[2] = m[1] * m[5] - m[2] * m[4];
				adj[3] = m[5] * m[6] - m[3] * m[8];
				adj[4] = m[0] * m[8] - m[2] * m[6];
				adj[5] = m[2] * m[3] - m[0] * m[5];
				adj[6] = m[3] * m[7] - m[4] * m[6];
				adj[7] = m[1] * m[6] - m[0] * m[7];
				adj[8] = m[0] * m[4] - m[1] * m[3];
				det    = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
				mag    = (det < 0) ? -det : det;
				rd     = (mag + (wide_t'(1) <<< 15)) >>> 16;
				if (det < 0) rd = -rd;
			end
		endcase
		r.det_value = clamp(rd, 64);
		limw        = 0;
		limw[31:0]  = lim;
		mag         = (rd < 0) ? -rd : rd;
		sing        = (det == 0) || (mag < limw);
		r.singular  = sing;
		if (!sing) begin
			for (int k = 0; k < n * n; k++) begin
				sat   = clamp(round_div(adj[k] <<< 32, det), 32);
				iv[k] = sat[31:0];
			end
		end
		r.inv0 = iv[0]; r.inv1 = iv[1]; r.inv2 = iv[2];
		r.inv3 = iv[3]; r.inv4 = iv[4]; r.inv5 = iv[5];
		r.inv6 = iv[6]; r.inv7 = iv[7]; r.inv8 = iv[8];
		return r;
	endfunction

	// pick an element: mostly small values, some full range, some extremes
	function automatic logic [31:0] pick_elem();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5) return $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
		if (sel < 8) return $urandom;
		if (sel == 8) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hffff_ffff;
	endfunction

	function automatic src_t pick_matrix();
		src_t s;
		s.mode  = ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
		s.elem0 = pick_elem(); s.elem1 = pick_elem(); s.elem2 = pick_elem();
		s.elem3 = pick_elem(); s.elem4 = pick_elem(); s.elem5 = pick_elem();
		s.elem6 = pick_elem(); s.elem7 = pick_elem(); s.elem8 = pick_elem();
		// make some matrices singular by repeating a row
		if ($urandom_range(0, 15) == 0) begin
			s.elem6 = s.elem0; s.elem7 = s.elem1; s.elem8 = s.elem2;
			if (s.mode == MODE_2) begin
				s.elem2 = s.elem0; s.elem3 = s.elem1;
			end
		end
		return s;
	endfunction

	function automatic src_t mk(logic [1:0] md, logic [31:0] e0, logic [31:0] e1,
			logic [31:0] e2, logic [31:0] e3, logic [31:0] e4, logic [31:0] e5,
			logic [31:0] e6, logic [31:0] e7, logic [31:0] e8);
		src_t s;
		s.mode  = md;
		s.elem0 = e0; s.elem1 = e1; s.elem2 = e2;
		s.elem3 = e3; s.elem4 = e4; s.elem5 = e5;
		s.elem6 = e6; s.elem7 = e7; s.elem8 = e8;
		return s;
	endfunction

	// drive one matrix, in bursts with random gaps; valid stays high inside a burst
	task automatic send_matrix(src_t s);
		int gap;
		if (burst_left == 0) begin
			if (src_valid) begin
				src_valid <= 1'b0;
				gap = $urandom_range(1, 6);
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
		end
		burst_left--;
		src_valid <= 1'b1;
		src_data  <= s;
		do @(posedge clk); while (src_stall);
		inverse_q.push_back(inverse_of(s, limit_shadow));
	endtask

	task automatic push_typed(src_t s, res_t r);
		if (burst_left == 0) burst_left = 1;
		burst_left--;
		src_valid <= 1'b1;
		src_data  <= s;
		do @(posedge clk); while (src_stall);
		inverse_q.push_back(r);
	endtask

	// wait until idle, then write the singular limit
	task automatic write_limit(logic [31:0] v);
		src_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (inverse_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_shadow = v;
	endtask

	// receiver stall pattern: switch between free, light and heavy stalling
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0:       res_stall <= 1'b0;
			1:       res_stall <= ($urandom_range(0, 3) == 0);
			default: res_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// compare each result beat with the oldest expected inverse
	always @(posedge clk) begin
		res_t        want;
		logic [31:0] wi;
		logic [31:0] gi;
		if (arst_n && res_valid && !res_stall) begin
			if (inverse_q.size() == 0) begin
				$error("result beat with no matrix pending");
				fail_count++;
			end else begin
				want = inverse_q.pop_front();
				for (int k = 0; k < 9; k++) begin
					wi = want[65 + 32 * (8 - k) +: 32];
					gi = res_data[65 + 32 * (8 - k) +: 32];
					if (wi !== gi) begin
						$error("inv%0d expected %h got %h", k, wi, gi);
						fail_count++;
					end
				end
				if (want.det_value !== res_data.det_value) begin
					$error("det_value expected %h got %h", want.det_value,
						res_data.det_value);
					fail_count++;
				end
				if (want.singular !== res_data.singular) begin
					$error("singular expected %b got %b", want.singular,
						res_data.singular);
					fail_count++;
				end
			end
		end
	end

	initial begin
		res_t r;
		arst_n       = 1'b0;
		src_valid    = 1'b0;
		src_data     = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		res_stall    = 1'b0;
		stall_mode   = 0;
		burst_left   = 0;
		fail_count   = 0;
		limit_shadow = 32'd1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed matrices; typed rows carry their expected result
		r = '0; r.singular = 1'b1;
		rows.push_back('{mk(2'd0, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1, r});
		r = '0; r.inv0 = 32'h0001_0000; r.det_value = 64'h1_0000_0000;
		rows.push_back('{mk(MODE_1, 32'h0001_0000, '1, '1, '1, '1, '1, '1, '1, '1), 1, r});
		r = '0; r.inv0 = 32'h0001_0000; r.inv3 = 32'h0001_0000;
		r.det_value = 64'h1_0000_0000;
		rows.push_back('{mk(MODE_2, 32'h0001_0000, 0, 0, 32'h0001_0000,
			'1, '1, '1, '1, '1), 1, r});
		r = '0; r.inv0 = 32'h0001_0000; r.inv4 = 32'h0001_0000;
		r.inv8 = 32'h0001_0000; r.det_value = 64'h1_0000_0000;
		rows.push_back('{mk(MODE_3, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0,
			0, 0, 32'h0001_0000), 1, r});
		r = '0; r.singular = 1'b1;
		rows.push_back('{mk(MODE_2, 0, 0, 0, 0, '1, '1, '1, '1, '1), 1, r});
		rows.push_back('{mk(MODE_3, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, r});
		rows.push_back('{mk(MODE_1, 0, '1, '1, '1, '1, '1, '1, '1, '1), 1, r});
		rows.push_back('{mk(MODE_1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, r});
		rows.push_back('{mk(MODE_1, '1, 0, 0, 0, 0, 0, 0, 0, 0), 0, r});
		rows.push_back('{mk(MODE_1, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0, 0), 0, r});
		rows.push_back('{mk(MODE_1, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0), 0, r});
		rows.push_back('{mk(MODE_2, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 0, 0, 0, 0, 0), 0, r});
		rows.push_back('{mk(MODE_2, 0, 32'h0001_0000, 32'h0001_0000, 0,
			'1, '1, '1, '1, '1), 0, r});
		rows.push_back('{mk(MODE_2, 32'h0002_0000, 32'h0000_8000, 32'h0000_4000,
			32'h0003_0000, 0, 0, 0, 0, 0), 0, r});
		rows.push_back('{mk(MODE_3, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff), 0, r});
		rows.push_back('{mk(MODE_3, 32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff, 0,
			0, 0, 32'h7fff_ffff), 0, r});
		// tiny determinant: rounds to zero but is not exactly zero
		rows.push_back('{mk(MODE_3, 1, 0, 0, 0, 1, 0, 0, 0, 1), 0, r});
		rows.push_back('{mk(MODE_3, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
			32'h0002_0000, 32'h0004_0000, 32'h0006_0000, 32'h0001_0000,
			0, 32'h0001_0000), 0, r});
		rows.push_back('{mk(MODE_3, 32'h0002_0000, 32'hffff_0000, 0,
			32'hffff_0000, 32'h0002_0000, 32'hffff_0000, 0, 32'hffff_0000,
			32'h0002_0000), 0, r});
		rows.push_back('{mk(MODE_2, 1, 0, 0, 1, 0, 0, 0, 0, 0), 0, r});

		foreach (rows[i]) begin
			if (rows[i].typed) push_typed(rows[i].m, rows[i].r);
			else send_matrix(rows[i].m);
		end

		// zero limit: only exact zero is singular; tiny determinants overflow
		write_limit(32'd0);
		send_matrix(mk(MODE_3, 1, 0, 0, 0, 1, 0, 0, 0, 1));
		send_matrix(mk(MODE_2, 1, 0, 0, 1, 0, 0, 0, 0, 0));
		for (int i = 0; i < 500; i++) send_matrix(pick_matrix());

		// largest limit: nearly everything is singular
		write_limit(32'hffff_ffff);
		for (int i = 0; i < 300; i++) send_matrix(pick_matrix());

		// random limits
		for (int p = 0; p < 3; p++) begin
			write_limit($urandom);
			for (int i = 0; i < 300; i++) send_matrix(pick_matrix());
		end

		write_limit(32'd1);
		for (int i = 0; i < 300; i++) send_matrix(pick_matrix());

		src_valid <= 1'b0;
		@(posedge clk);
		while (inverse_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS small_matrix_inverse");
		end else begin
			$display("FAIL small_matrix_inverse");
		end
		$finish;
	end

endmodule
